@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) (cond)) else $error(msg);

`endif

@@ hw/rtl/mtep_pkg.sv @@
package mtep_pkg;

  // Default size of the active-note table.
  localparam int unsigned ActiveSlotsDef = 32;
  localparam int unsigned EntryW = 50;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NOTE      = 3'd0,
    KIND_TEMPO     = 3'd1,
    KIND_SUSTAIN   = 3'd2,
    KIND_TRACK_END = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  // Error codes.
  localparam logic [1:0] ERR_VARLEN  = 2'd0;
  localparam logic [1:0] ERR_NO_RS   = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;

  // Status and meta codes.
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [3:0] TY_NOTE_OFF = 4'h8;
  localparam logic [3:0] TY_NOTE_ON  = 4'h9;
  localparam logic [3:0] TY_CTRL     = 4'hB;
  localparam logic [3:0] TY_PROG     = 4'hC;
  localparam logic [3:0] TY_PRESS    = 4'hD;
  localparam logic [3:0] TY_SYSTEM   = 4'hF;
  localparam logic [6:0] CTRL_SUSTAIN = 7'd64;

  // One active note as stored in the table.
  typedef struct packed {
    logic [31:0] start;
    logic [6:0]  vel;
    logic [3:0]  chan;
    logic [6:0]  key;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] start;
    logic [31:0] tick;
    logic [23:0] tempo;
    logic        pedal;
    logic [1:0]  ecode;
  } res_t;

endpackage

@@ hw/rtl/midi_track_event_parser_top.sv @@
// Track chunk parser for Standard MIDI File data.
// Input channel: one chunk byte per word (data_byte_i), chunk_end_i on the final byte.
// Output channel: result words (note, tempo, sustain, track end, error), last_o marks
// the final word caused by one input byte.
// A byte is taken only while the parser is idle; it then passes through the parse,
// chunk-end and release steps before the next is taken. A note-off searches the note
// table newest first, reading and comparing one entry at a time, then closes the gap
// by moving each entry above the hit one place down. The flush reads the table in order.
// Active notes live in one single-port-write, registered-read memory; only the fill
// count is reset, so no clearing pass is needed.
// Reset returns the parser to the start of a chunk with an empty table and no
// running status. When the receiver stalls, one finished word waits in the output
// register and one more in a holding register; the parser then waits for room.
module midi_track_event_parser_top #(
  parameter int unsigned ActiveSlots = mtep_pkg::ActiveSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  note_number_o,
  output logic [6:0]  velocity_o,
  output logic [31:0] start_tick_o,
  output logic [31:0] end_tick_o,
  output logic [23:0] tempo_us_o,
  output logic        pedal_down_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);
  import mtep_pkg::*;

  localparam int unsigned CW = $clog2(ActiveSlots + 1);
  localparam int unsigned AW = (ActiveSlots > 1) ? $clog2(ActiveSlots) : 1;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_META_TYPE, PH_META_LEN, PH_META_DATA,
    PH_SYSEX_LEN, PH_SYSEX_DATA, PH_DATA1, PH_DATA2, PH_EOT, PH_DISCARD
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PARSE, S_SRD, S_SCMP, S_SHR, S_SHW, S_SEMIT, S_POST,
    S_FRD, S_FCMP, S_FEND, S_DONE
  } state_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  rs_q, rs_d;
  logic [31:0] tick_q, tick_d;
  logic [27:0] vl_q, vl_d;
  logic [2:0]  vc_q, vc_d;
  logic [7:0]  mt_q, mt_d;
  logic [27:0] skip_q, skip_d;
  logic [7:0]  es_q, es_d;
  logic [6:0]  fd_q, fd_d;
  logic [23:0] ts_q, ts_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  entry_t      hit_q, hit_d;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;

  // Table memory ports.
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [CW-1:0] raddr_w;
  entry_t        rdata;

  // Result handoff.
  logic push, done, ob_rdy;
  res_t res, ores;
  logic olast;

  // Parse helpers.
  logic [27:0] vl_new;
  logic [2:0]  vc_new;
  logic        vt_long;
  logic [32:0] tick_sum;
  logic [27:0] skip_dec;
  logic [23:0] ts_new;
  logic [7:0]  mt_eff;
  logic [CW-1:0] k_dec, j_inc;
  logic        clean, clear_parse;

  assign vl_new   = {vl_q[20:0], byte_q[6:0]};
  assign vc_new   = vc_q + 3'd1;
  assign vt_long  = byte_q[7] && (vc_new >= 3'd4);
  assign tick_sum = {1'b0, tick_q} + {5'd0, vl_new};
  assign skip_dec = skip_q - 28'd1;
  assign ts_new   = {ts_q[15:0], byte_q};
  assign k_dec    = k_q - CW'(1);
  assign j_inc    = k_q + CW'(1);
  assign clean    = (phase_q == PH_STATUS) || (phase_q == PH_EOT) ||
                    ((phase_q == PH_DELTA) && (vc_q == 3'd0));

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    rs_d    = rs_q;
    tick_d  = tick_q;
    vl_d    = vl_q;
    vc_d    = vc_q;
    mt_d    = mt_q;
    skip_d  = skip_q;
    es_d    = es_q;
    fd_d    = fd_q;
    ts_d    = ts_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    hit_d   = hit_q;
    byte_d  = byte_q;
    end_d   = end_q;
    we      = 1'b0;
    waddr   = cnt_q[AW-1:0];
    wdata   = entry_t'({tick_q, byte_q[6:0], es_q[3:0], fd_q});
    re      = 1'b0;
    raddr_w = k_q;
    push    = 1'b0;
    done    = 1'b0;
    res     = '0;
    res.tick = tick_q;
    clear_parse = 1'b0;
    mt_eff  = mt_q;

    case (state_q)
      // Take the next byte.
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d  = data_byte_i;
          end_d   = chunk_end_i;
          state_d = S_PARSE;
        end
      end

      // Advance the parse by one byte.
      S_PARSE: begin
        state_d = S_POST;
        case (phase_q)
          PH_DELTA: begin
            vl_d = vl_new;
            vc_d = vc_new;
            if (vt_long) begin
              push = 1'b1; res.kind = KIND_ERROR; res.ecode = ERR_VARLEN;
              phase_d = PH_DISCARD;
            end else if (!byte_q[7]) begin
              tick_d  = tick_sum[32] ? '1 : tick_sum[31:0];
              vl_d    = '0;
              vc_d    = '0;
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (!byte_q[7]) begin
              if (rs_q == 8'd0) begin
                push = 1'b1; res.kind = KIND_ERROR; res.ecode = ERR_NO_RS;
                phase_d = PH_DISCARD;
              end else begin
                // Running status: this byte is the first data byte.
                es_d = rs_q;
                fd_d = byte_q[6:0];
                if (rs_q[7:4] == TY_PROG || rs_q[7:4] == TY_PRESS) begin
                  phase_d = PH_DELTA;
                end else begin
                  phase_d = PH_DATA2;
                end
              end
            end else begin
              rs_d = (byte_q[7:4] == TY_SYSTEM) ? 8'd0 : byte_q;
              es_d = byte_q;
              if (byte_q == ST_META) begin
                phase_d = PH_META_TYPE;
              end else if (byte_q == ST_SYSEX || byte_q == ST_SYSEX_CT) begin
                vl_d = '0; vc_d = '0;
                phase_d = PH_SYSEX_LEN;
              end else if (byte_q[7:4] == TY_SYSTEM) begin
                push = 1'b1; res.kind = KIND_ERROR; res.ecode = ERR_UNKNOWN;
                phase_d = PH_DISCARD;
              end else begin
                phase_d = PH_DATA1;
              end
            end
          end
          PH_META_TYPE: begin
            mt_d = byte_q;
            vl_d = '0; vc_d = '0;
            phase_d = PH_META_LEN;
          end
          PH_META_LEN: begin
            vl_d = vl_new;
            vc_d = vc_new;
            if (vt_long) begin
              push = 1'b1; res.kind = KIND_ERROR; res.ecode = ERR_VARLEN;
              phase_d = PH_DISCARD;
            end else if (!byte_q[7]) begin
              if (mt_q == META_TEMPO && vl_new != 28'd3) begin
                mt_eff = 8'd0;
              end
              mt_d   = mt_eff;
              ts_d   = '0;
              skip_d = vl_new;
              vl_d   = '0; vc_d = '0;
              if (vl_new == 28'd0) begin
                if (mt_eff == META_EOT) begin
                  phase_d = PH_EOT;
                end else begin
                  phase_d = PH_DELTA;
                end
              end else begin
                phase_d = PH_META_DATA;
              end
            end
          end
          PH_META_DATA: begin
            if (mt_q == META_TEMPO) begin
              ts_d = ts_new;
            end
            skip_d = skip_dec;
            if (skip_dec == 28'd0) begin
              if (mt_q == META_EOT) begin
                phase_d = PH_EOT;
              end else begin
                if (mt_q == META_TEMPO) begin
                  push = 1'b1; res.kind = KIND_TEMPO; res.tempo = ts_new;
                end
                vl_d = '0; vc_d = '0;
                phase_d = PH_DELTA;
              end
            end
          end
          PH_SYSEX_LEN: begin
            vl_d = vl_new;
            vc_d = vc_new;
            if (vt_long) begin
              push = 1'b1; res.kind = KIND_ERROR; res.ecode = ERR_VARLEN;
              phase_d = PH_DISCARD;
            end else if (!byte_q[7]) begin
              skip_d = vl_new;
              vl_d   = '0; vc_d = '0;
              phase_d = (vl_new == 28'd0) ? PH_DELTA : PH_SYSEX_DATA;
            end
          end
          PH_SYSEX_DATA: begin
            skip_d = skip_dec;
            if (skip_dec == 28'd0) begin
              phase_d = PH_DELTA;
            end
          end
          PH_DATA1: begin
            fd_d = byte_q[6:0];
            if (es_q[7:4] == TY_PROG || es_q[7:4] == TY_PRESS) begin
              vl_d = '0; vc_d = '0;
              phase_d = PH_DELTA;
            end else begin
              phase_d = PH_DATA2;
            end
          end
          PH_DATA2: begin
            vl_d = '0; vc_d = '0;
            phase_d = PH_DELTA;
            if (es_q[7:4] == TY_NOTE_ON && byte_q[6:0] != 7'd0) begin
              // Append the note if there is room, else drop it.
              if (cnt_q < CW'(ActiveSlots)) begin
                we    = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
            end else if (es_q[7:4] == TY_NOTE_OFF || es_q[7:4] == TY_NOTE_ON) begin
              if (cnt_q != '0) begin
                k_d     = cnt_q;
                state_d = S_SRD;
              end
            end else if (es_q[7:4] == TY_CTRL && fd_q == CTRL_SUSTAIN) begin
              push = 1'b1; res.kind = KIND_SUSTAIN; res.channel = es_q[3:0];
              res.pedal = byte_q[6];
            end
          end
          default: ;
        endcase
        // Hold everything while the result cannot be taken.
        if (push && !ob_rdy) begin
          state_d = state_q; phase_d = phase_q; rs_d = rs_q; tick_d = tick_q;
          vl_d = vl_q; vc_d = vc_q; mt_d = mt_q; skip_d = skip_q; es_d = es_q;
          fd_d = fd_q; ts_d = ts_q; cnt_d = cnt_q; k_d = k_q;
          we = 1'b0;
        end
      end

      // Read the next older table entry.
      S_SRD: begin
        re      = 1'b1;
        raddr_w = k_dec;
        state_d = S_SCMP;
      end

      // Compare it with the note-off key.
      S_SCMP: begin
        if (rdata.chan == es_q[3:0] && rdata.key == fd_q) begin
          hit_d   = rdata;
          k_d     = k_dec;
          state_d = S_SHR;
        end else begin
          k_d     = k_dec;
          state_d = (k_dec == '0) ? S_POST : S_SRD;
        end
      end

      // Close the gap: read the entry above.
      S_SHR: begin
        if (j_inc >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_SEMIT;
        end else begin
          re      = 1'b1;
          raddr_w = j_inc;
          state_d = S_SHW;
        end
      end

      // Move it down one place.
      S_SHW: begin
        we      = 1'b1;
        waddr   = k_q[AW-1:0];
        wdata   = rdata;
        k_d     = j_inc;
        state_d = S_SHR;
      end

      // Report the finished note if it lasted.
      S_SEMIT: begin
        res.kind    = KIND_NOTE;
        res.channel = hit_q.chan;
        res.note    = hit_q.key;
        res.vel     = hit_q.vel;
        res.start   = hit_q.start;
        push        = tick_q > hit_q.start;
        if (!push || ob_rdy) begin
          state_d = S_POST;
        end
      end

      // Handle the chunk end.
      S_POST: begin
        state_d = S_DONE;
        if (end_q) begin
          if (phase_q == PH_DISCARD) begin
            clear_parse = 1'b1;
          end else if (clean) begin
            k_d     = '0;
            state_d = S_FRD;
          end else begin
            push      = 1'b1;
            res.kind  = KIND_ERROR;
            res.ecode = ERR_TRUNC;
            if (ob_rdy) begin
              clear_parse = 1'b1;
            end else begin
              state_d = S_POST;
            end
          end
        end
      end

      // Flush: read entries in table order.
      S_FRD: begin
        if (k_q == cnt_q) begin
          state_d = S_FEND;
        end else begin
          re      = 1'b1;
          state_d = S_FCMP;
        end
      end

      S_FCMP: begin
        res.kind    = KIND_NOTE;
        res.channel = rdata.chan;
        res.note    = rdata.key;
        res.vel     = rdata.vel;
        res.start   = rdata.start;
        push        = tick_q > rdata.start;
        if (!push || ob_rdy) begin
          k_d     = j_inc;
          state_d = S_FRD;
        end
      end

      // Report the track end and restart.
      S_FEND: begin
        push     = 1'b1;
        res.kind = KIND_TRACK_END;
        if (ob_rdy) begin
          clear_parse = 1'b1;
          state_d     = S_DONE;
        end
      end

      // Release the held word with its last flag.
      S_DONE: begin
        done = 1'b1;
        if (ob_rdy) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Drop back to the start of a chunk.
    if (clear_parse) begin
      phase_d = PH_DELTA;
      rs_d = '0; tick_d = '0; vl_d = '0; vc_d = '0; mt_d = '0; skip_d = '0;
      es_d = '0; fd_d = '0; ts_d = '0; cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_DELTA;
      rs_q    <= '0;
      tick_q  <= '0;
      vl_q    <= '0;
      vc_q    <= '0;
      mt_q    <= '0;
      skip_q  <= '0;
      es_q    <= '0;
      fd_q    <= '0;
      ts_q    <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      hit_q   <= '0;
      byte_q  <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rs_q    <= rs_d;
      tick_q  <= tick_d;
      vl_q    <= vl_d;
      vc_q    <= vc_d;
      mt_q    <= mt_d;
      skip_q  <= skip_d;
      es_q    <= es_d;
      fd_q    <= fd_d;
      ts_q    <= ts_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      hit_q   <= hit_d;
      byte_q  <= byte_d;
      end_q   <= end_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  mtep_ram #(
    .Width(EntryW),
    .Depth(ActiveSlots),
    .AddrW(AW)
  ) u_notes (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr_w[AW-1:0]),
    .rdata_o(rdata)
  );

  mtep_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res),
    .done_i     (done),
    .rdy_o      (ob_rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (ores),
    .out_last_o (olast)
  );

  assign kind_o        = ores.kind;
  assign channel_o     = ores.channel;
  assign note_number_o = ores.note;
  assign velocity_o    = ores.vel;
  assign start_tick_o  = ores.start;
  assign end_tick_o    = ores.tick;
  assign tempo_us_o    = ores.tempo;
  assign pedal_down_o  = ores.pedal;
  assign error_code_o  = ores.ecode;
  assign last_o        = olast;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_range, (!rst_ni || cnt_q <= CW'(ActiveSlots)), "note count overflow")
  `ASSERT_CLK(a_accept_parse, (in_valid_i && !in_stall_o) |=> (state_q == S_PARSE), "byte not parsed")
  `ASSERT_CLK(a_we_state, we |-> (state_q == S_PARSE || state_q == S_SHW), "stray table write")
  `ASSERT_CLK(a_done_idle, (state_q == S_IDLE) |-> (push == 1'b0), "result pushed while idle")

endmodule

@@ hw/rtl/mtep_ram.sv @@
module mtep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mtep_out_stage.sv @@
module mtep_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtep_pkg::res_t res_i,
  input  logic           done_i,
  output logic           rdy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtep_pkg::res_t out_res_o,
  output logic           out_last_o
);
  import mtep_pkg::*;

  logic pend_v_q, pend_v_d;
  res_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  res_t out_q, out_d;
  logic last_q, last_d;
  logic out_free;

  // A word is held back until the next one or the end of the byte tells its last flag.
  assign out_free = !out_v_q || !out_stall_i;
  assign rdy_o    = !pend_v_q || out_free;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    last_d   = last_q;
    if (push_i && rdy_o) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_d   = pend_q;
        last_d  = 1'b0;
      end
      pend_d   = res_i;
      pend_v_d = 1'b1;
    end else if (done_i && pend_v_q && out_free) begin
      out_v_d  = 1'b1;
      out_d    = pend_q;
      last_d   = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = last_q;

endmodule
